[sv/ibd_pkg.sv]
package ibd_pkg;

   localparam int VALUE_BITS = 31;
   localparam int MAX_BASE   = 16;

   localparam int DIGIT_W    = $clog2(MAX_BASE);
   localparam int RADIX_W    = $clog2(MAX_BASE + 1);
   localparam int CHAR_W     = 8;
   localparam int BASE_REG_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CHARS_W    = MAX_BASE * CHAR_W;

   // digit index within one number and digit count of one number
   localparam int IDX_W      = $clog2(VALUE_BITS);
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);

   // divider retires STEP_BITS quotient bits per cycle
   localparam int STEP_BITS  = 8;
   localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_WIDTH  = DIV_CYCLES * STEP_BITS;
   localparam int STEP_CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   // digit queue between divider and emitter
   localparam int NUM_SLOTS  = 2;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int FILL_W     = $clog2(NUM_SLOTS + 1);
   localparam int RAM_DEPTH  = NUM_SLOTS << IDX_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_LOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_HIGH  = 2'd2;

   localparam logic [BASE_REG_W-1:0] BASE_LENGTH_RST = 5'd8;
   localparam logic [CSR_DATA_W-1:0] CHARS_LOW_RST   = 64'h3736353433323130;
   localparam logic [CSR_DATA_W-1:0] CHARS_HIGH_RST  = 64'h0;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_WRITE
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_FETCH,
      B_HOLD
   } back_state_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   idx;
      logic [DIGIT_W-1:0] digit;
      logic               push;
      logic [CNT_W-1:0]   count;
   } queue_wr_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] idx;
      logic             pop;
   } queue_rd_type;

   typedef struct packed {
      logic             head_valid;
      logic [CNT_W-1:0] head_count;
   } queue_head_type;

endpackage

[sv/ibd_ram.sv]
module ibd_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ibd_front.sv]
module ibd_front
   import ibd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [RADIX_W-1:0]    radix,
   input  logic                  queue_full,
   output queue_wr_type          queue_wr
);

   front_state_type        state_ff, state_in;
   logic [DIV_WIDTH-1:0]   work_ff, work_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [STEP_CNT_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]       n_ff, n_in;

   logic                   accept;
   logic                   last_step;
   logic                   last_digit;
   logic [STEP_BITS-1:0]   qbits;
   logic [DIGIT_W-1:0]     rem_step;

   assign accept     = req_valid && req_ready;
   assign last_step  = (step_ff == STEP_CNT_W'(DIV_CYCLES - 1));
   assign last_digit = (work_ff == '0) || (n_ff == CNT_W'(VALUE_BITS - 1));

   // restoring division by the radix, STEP_BITS dividend bits per cycle
   always_comb begin
      logic [DIGIT_W:0] t;
      logic [DIGIT_W:0] r;
      r = {1'b0, rem_ff};
      qbits = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         t = {r[DIGIT_W-1:0], work_ff[DIV_WIDTH-1-i]};
         if (t >= (DIGIT_W+1)'(radix)) begin
            t = t - (DIGIT_W+1)'(radix);
            qbits[STEP_BITS-1-i] = 1'b1;
         end
         r = t;
      end
      rem_step = r[DIGIT_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            if (last_step) begin
               state_in = F_WRITE;
            end
         end
         F_WRITE: begin
            state_in = last_digit ? F_IDLE : F_DIV;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      queue_wr  = '0;
      work_in   = work_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      n_in      = n_ff;
      case (state_ff)
         F_IDLE: begin
            req_ready = !queue_full;
            work_in   = DIV_WIDTH'(req_value);
            rem_in    = '0;
            step_in   = '0;
            n_in      = '0;
         end
         F_DIV: begin
            work_in = {work_ff[DIV_WIDTH-STEP_BITS-1:0], qbits};
            rem_in  = rem_step;
            step_in = step_ff + STEP_CNT_W'(1);
         end
         F_WRITE: begin
            // work_ff now holds the quotient, rem_ff the digit
            queue_wr.we    = 1'b1;
            queue_wr.idx   = n_ff[IDX_W-1:0];
            queue_wr.digit = rem_ff;
            queue_wr.push  = last_digit;
            queue_wr.count = n_ff + CNT_W'(1);
            rem_in         = '0;
            step_in        = '0;
            n_in           = n_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      n_ff    <= n_in;
   end

endmodule

[sv/ibd_queue.sv]
module ibd_queue
   import ibd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_wr_type   queue_wr,
   output logic           queue_full,
   input  queue_rd_type   queue_rd,
   output queue_head_type queue_head,
   output logic [DIGIT_W-1:0] rd_digit
);

   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  count_ff [NUM_SLOTS];

   always_comb begin
      wr_slot_in = wr_slot_ff;
      rd_slot_in = rd_slot_ff;
      fill_in    = fill_ff;
      if (queue_wr.push) begin
         wr_slot_in = wr_slot_ff + SLOT_W'(1);
      end
      if (queue_rd.pop) begin
         rd_slot_in = rd_slot_ff + SLOT_W'(1);
      end
      case ({queue_wr.push, queue_rd.pop})
         2'b10:   fill_in = fill_ff + FILL_W'(1);
         2'b01:   fill_in = fill_ff - FILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff <= '0;
         rd_slot_ff <= '0;
         fill_ff    <= '0;
      end else begin
         wr_slot_ff <= wr_slot_in;
         rd_slot_ff <= rd_slot_in;
         fill_ff    <= fill_in;
      end
      if (queue_wr.push) begin
         count_ff[wr_slot_ff] <= queue_wr.count;
      end
   end

   assign queue_full            = (fill_ff == FILL_W'(NUM_SLOTS));
   assign queue_head.head_valid = (fill_ff != '0);
   assign queue_head.head_count = count_ff[rd_slot_ff];

   ibd_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (RAM_DEPTH)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (queue_wr.we),
      .wr_addr ({wr_slot_ff, queue_wr.idx}),
      .wr_data (queue_wr.digit),
      .rd_en   (queue_rd.rd_en),
      .rd_addr ({rd_slot_ff, queue_rd.idx}),
      .rd_data (rd_digit)
   );

endmodule

[sv/ibd_back.sv]
module ibd_back
   import ibd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  queue_head_type     queue_head,
   output queue_rd_type       queue_rd,
   input  logic [DIGIT_W-1:0] rd_digit,
   input  logic [CHARS_W-1:0] digit_chars,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_is_last
);

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic [IDX_W-1:0]    first_pos;

   assign first_pos = IDX_W'(queue_head.head_count - CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (queue_head.head_valid) begin
               state_in = B_FETCH;
            end
         end
         B_FETCH: begin
            state_in = B_HOLD;
         end
         B_HOLD: begin
            if (rsp_ready) begin
               state_in = last_ff ? B_IDLE : B_FETCH;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      queue_rd = '0;
      pos_in   = pos_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      case (state_ff)
         B_IDLE: begin
            // start from the most significant digit
            queue_rd.rd_en = queue_head.head_valid;
            queue_rd.idx   = first_pos;
            pos_in         = first_pos;
         end
         B_FETCH: begin
            char_in = digit_chars[{rd_digit, 3'b000} +: CHAR_W];
            last_in = (pos_ff == '0);
         end
         B_HOLD: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  queue_rd.pop = 1'b1;
               end else begin
                  queue_rd.rd_en = 1'b1;
                  queue_rd.idx   = pos_ff - IDX_W'(1);
                  pos_in         = pos_ff - IDX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pos_ff  <= pos_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = (state_ff == B_HOLD);
   assign rsp_out_char = char_ff;
   assign rsp_is_last  = last_ff;

endmodule

[sv/integer_to_base_digits.sv]
// Converts a non-negative integer to its digits in a programmable base (2 to 16), most
// significant digit first, one character per result; each digit is looked up in a 16-entry
// character table held in two 64-bit registers, and the final character of a number is
// flagged with rsp_is_last (zero yields the single digit for 0). A base_length of 0 or 1
// acts as 2, above 16 acts as 16. The divider retires 8 quotient bits per cycle; each digit
// is formed by the divide steps followed by a write into the digit queue. The emitter reads
// the digit memory with a registered read, fetching each digit before presenting its
// character, and holds each character until rsp_ready is high. A two-number digit queue sits
// between divider and emitter, so the next number converts while the previous one is still
// being emitted; sustained throughput is set by whichever side is slower, the divider
// whenever rsp_ready stays high. Write the configuration registers only while no conversion
// is in flight.
module integer_to_base_digits
   import ibd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_W-1:0]     rsp_out_char,
   output logic                  rsp_is_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [BASE_REG_W-1:0] base_length_ff;
   logic [CSR_DATA_W-1:0] chars_low_ff;
   logic [CSR_DATA_W-1:0] chars_high_ff;
   logic [RADIX_W-1:0]    radix;

   queue_wr_type          queue_wr;
   queue_rd_type          queue_rd;
   queue_head_type        queue_head;
   logic                  queue_full;
   logic [DIGIT_W-1:0]    rd_digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff <= BASE_LENGTH_RST;
         chars_low_ff   <= CHARS_LOW_RST;
         chars_high_ff  <= CHARS_HIGH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_LENGTH: base_length_ff <= csr_wdata[BASE_REG_W-1:0];
            CSR_CHARS_LOW:   chars_low_ff   <= csr_wdata;
            CSR_CHARS_HIGH:  chars_high_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // clamp the radix into the range the digit table covers
   always_comb begin
      if (base_length_ff < BASE_REG_W'(2)) begin
         radix = RADIX_W'(2);
      end else if (base_length_ff > BASE_REG_W'(MAX_BASE)) begin
         radix = RADIX_W'(MAX_BASE);
      end else begin
         radix = RADIX_W'(base_length_ff);
      end
   end

   ibd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .radix      (radix),
      .queue_full (queue_full),
      .queue_wr   (queue_wr)
   );

   ibd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .queue_full (queue_full),
      .queue_rd   (queue_rd),
      .queue_head (queue_head),
      .rd_digit   (rd_digit)
   );

   ibd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_head   (queue_head),
      .queue_rd     (queue_rd),
      .rd_digit     (rd_digit),
      .digit_chars  ({chars_high_ff, chars_low_ff}),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_is_last  (rsp_is_last)
   );

endmodule
